>>> hw/rtl/csif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csif_pkg
// Shared widths, phase codes and status codes of the chunk stream filter.
// ----------------------------------------------------------------------------
package csif_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CountW  = 2;

  // last byte index of a 4-byte header field
  localparam logic [CountW-1:0] FieldLastByte = 2'd3;

  // walk phases; the unused code behaves as the tag phase
  localparam logic [PhaseW-1:0] PhTag = 2'd0;
  localparam logic [PhaseW-1:0] PhLen = 2'd1;
  localparam logic [PhaseW-1:0] PhPay = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] StRunning   = 2'd0;
  localparam logic [StatusW-1:0] StFound     = 2'd1;
  localparam logic [StatusW-1:0] StNotFound  = 2'd2;
  localparam logic [StatusW-1:0] StTruncated = 2'd3;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [StatusW-1:0] status_t;

endpackage

>>> hw/rtl/csif_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csif_in_if / csif_out_if
// Valid/ready channels carrying file bytes in and payload results out.
// ----------------------------------------------------------------------------
interface csif_in_if
  import csif_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface csif_out_if
  import csif_pkg::*;
();
  logic    valid;
  logic    ready;
  byte_t   out_byte;
  logic    payload_valid;
  logic    payload_last;
  status_t status;

  modport source (output valid, output out_byte, output payload_valid,
                  output payload_last, output status, input ready);
  modport sink   (input valid, input out_byte, input payload_valid,
                  input payload_last, input status, output ready);
endinterface

>>> hw/rtl/chunk_stream_id_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_stream_id_filter
// Walks a tagged chunk file and forwards the payload of the first chunk
// whose tag equals target_tag.
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one file byte per word, end_of_file set on the last byte
//   out_ch : one result word per matching payload byte, per zero-length
//            match and per end_of_file byte; bytes that make no result
//            (headers, skipped payloads, bytes after the match) vanish
//   cfg    : cfg_we/cfg_wdata write target_tag, first tag char in top byte;
//            write only while the block is idle
// timing
//   one input word per cycle when not stalled; a result shows on out_ch in
//   the cycle after its word is taken. the whole walk is one pass of shift,
//   compare and count logic between the walk registers and output register
// stall
//   in_ch.ready stays high while the output register is empty or is being
//   drained this cycle, so a stalled receiver holds at most one result and
//   stops the input only while that result waits
// reset
//   rst (synchronous) clears the walk to the tag phase, empties the output
//   register and sets target_tag to zero; end_of_file also returns the walk
//   to the tag phase but keeps target_tag
// ----------------------------------------------------------------------------
module chunk_stream_id_filter
  import csif_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  word_t          cfg_wdata,
  csif_in_if.sink        in_ch,
  csif_out_if.source     out_ch
);

  // configuration
  word_t target_tag;

  // walk state
  logic [PhaseW-1:0] phase, phase_next;
  logic [CountW-1:0] field_byte_count, field_byte_count_next;
  word_t             tag_shift, tag_shift_next;
  word_t             length_shift, length_shift_next;
  word_t             payload_remaining, payload_remaining_next;
  logic              chunk_matches, chunk_matches_next;
  logic              match_done, match_done_next;

  // output register
  logic    res_valid;
  byte_t   res_byte, res_byte_next;
  logic    res_pay_valid, res_pay_valid_next;
  logic    res_last, res_last_next;
  status_t res_status, res_status_next;
  logic    emit;

  logic  in_take;
  word_t length_word;
  word_t tag_word;
  logic  done_now;

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign tag_word    = {tag_shift[WordW-ByteW-1:0], in_ch.data_byte};
  assign length_word = {length_shift[WordW-ByteW-1:0], in_ch.data_byte};

  // one step of the walk for the byte on in_ch
  always_comb begin
    phase_next             = phase;
    field_byte_count_next  = field_byte_count;
    tag_shift_next         = tag_shift;
    length_shift_next      = length_shift;
    payload_remaining_next = payload_remaining;
    chunk_matches_next     = chunk_matches;
    match_done_next        = match_done;
    done_now               = 1'b0;
    emit                   = 1'b0;
    res_byte_next          = '0;
    res_pay_valid_next     = 1'b0;
    res_last_next          = 1'b0;

    if (!match_done) begin
      case (phase)
        PhLen: begin
          length_shift_next = length_word;
          if (field_byte_count == FieldLastByte) begin
            field_byte_count_next  = '0;
            payload_remaining_next = length_word;
            if (length_word == '0) begin
              // empty payload: a match completes right here
              phase_next = PhTag;
              if (chunk_matches) begin
                match_done_next = 1'b1;
                done_now        = 1'b1;
                emit            = 1'b1;
                res_last_next   = 1'b1;
              end
            end else begin
              phase_next = PhPay;
            end
          end else begin
            field_byte_count_next = field_byte_count + 1'b1;
          end
        end
        PhPay: begin
          payload_remaining_next = payload_remaining - 1'b1;
          if (chunk_matches) begin
            emit               = 1'b1;
            res_pay_valid_next = 1'b1;
            res_byte_next      = in_ch.data_byte;
            if (payload_remaining == word_t'(1)) begin
              res_last_next   = 1'b1;
              match_done_next = 1'b1;
              done_now        = 1'b1;
            end
          end
          if (payload_remaining == word_t'(1)) begin
            phase_next = PhTag;
          end
        end
        default: begin
          // tag phase, also taken by the unused code
          tag_shift_next = tag_word;
          if (field_byte_count == FieldLastByte) begin
            field_byte_count_next = '0;
            chunk_matches_next    = (tag_word == target_tag);
            length_shift_next     = '0;
            phase_next            = PhLen;
          end else begin
            field_byte_count_next = field_byte_count + 1'b1;
            phase_next            = PhTag;
          end
        end
      endcase
    end

    if (in_ch.end_of_file) begin
      emit = 1'b1;
      if (match_done_next) begin
        res_status_next = StFound;
      end else if (phase_next == PhPay && chunk_matches_next) begin
        res_status_next = StTruncated;
      end else begin
        res_status_next = StNotFound;
      end
      // back to idle for the next file
      phase_next             = PhTag;
      field_byte_count_next  = '0;
      tag_shift_next         = '0;
      length_shift_next      = '0;
      payload_remaining_next = '0;
      chunk_matches_next     = 1'b0;
      match_done_next        = 1'b0;
    end else begin
      res_status_next = done_now ? StFound : StRunning;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_tag <= '0;
    end else if (cfg_we) begin
      target_tag <= cfg_wdata;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PhTag;
      field_byte_count  <= '0;
      tag_shift         <= '0;
      length_shift      <= '0;
      payload_remaining <= '0;
      chunk_matches     <= 1'b0;
      match_done        <= 1'b0;
    end else if (in_take) begin
      phase             <= phase_next;
      field_byte_count  <= field_byte_count_next;
      tag_shift         <= tag_shift_next;
      length_shift      <= length_shift_next;
      payload_remaining <= payload_remaining_next;
      chunk_matches     <= chunk_matches_next;
      match_done        <= match_done_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_take) begin
      res_valid <= emit;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      res_byte      <= res_byte_next;
      res_pay_valid <= res_pay_valid_next;
      res_last      <= res_last_next;
      res_status    <= res_status_next;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.out_byte      = res_byte;
  assign out_ch.payload_valid = res_pay_valid;
  assign out_ch.payload_last  = res_last;
  assign out_ch.status        = res_status;

endmodule

>>> hw/rtl/csif_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csif_checker
// Port-level checks of the chunk stream filter, bound to its top level.
// ----------------------------------------------------------------------------
module csif_checker
  import csif_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    in_end_of_file,
  input logic    out_valid,
  input logic    out_ready,
  input byte_t   out_byte,
  input logic    out_payload_valid,
  input logic    out_payload_last,
  input status_t out_status
);

  // a result waiting on a stalled receiver keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every end of file gives a verdict on the next cycle
  a_eof_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_end_of_file |=> out_valid)
    else $error("no verdict after end of file");

  // the last payload word always closes a found match
  a_last_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload_last |-> out_status == StFound)
    else $error("payload_last without found status");

  // a running result is always a payload byte
  a_running_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == StRunning |-> out_payload_valid)
    else $error("running result without payload byte");

  // non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload_valid |-> out_byte == '0)
    else $error("nonzero byte on non-payload result");

endmodule

bind chunk_stream_id_filter csif_checker u_csif_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_end_of_file    (in_ch.end_of_file),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_byte          (out_ch.out_byte),
  .out_payload_valid (out_ch.payload_valid),
  .out_payload_last  (out_ch.payload_last),
  .out_status        (out_ch.status)
);

>>> test/chunk_stream_id_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_stream_id_filter_tb
// Feeds tagged chunk files byte by byte, predicts every payload word and
// end-of-file verdict, and checks what the filter sends out in order.
// ----------------------------------------------------------------------------
module chunk_stream_id_filter_tb;
  import csif_pkg::*;

  localparam int unsigned LiveWordsPerRound = 130;
  localparam int unsigned DrainLimit        = 2000;
  localparam int unsigned TimeLimitNs       = 5_000_000;

  // one file byte as it goes into the filter
  typedef struct packed {
    byte_t data;
    logic  eof;
  } file_word_t;

  // one word as it comes out of the filter
  typedef struct packed {
    byte_t   out_byte;
    logic    payload_valid;
    logic    payload_last;
    status_t status;
  } filter_word_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_we = 1'b0;
  word_t cfg_wdata = '0;

  csif_in_if  in_ch ();
  csif_out_if out_ch ();

  chunk_stream_id_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, and the words the filter still owes us
  file_word_t   file_words[$];
  filter_word_t want_words[$];
  byte_t        file_buf[$];

  int unsigned mismatches = 0;
  int unsigned live_words = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        src_idle = 1'b0;
  logic        sink_idle = 1'b0;
  file_word_t  next_word;

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the walk and of target_tag
  // ---------------------------------------------------------------------------
  word_t              target_model = '0;
  logic [PhaseW-1:0]  wk_phase = PhTag;
  logic [CountW-1:0]  wk_count = '0;
  word_t              wk_tag = '0;
  word_t              wk_len = '0;
  word_t              wk_left = '0;
  logic               wk_hit = 1'b0;
  logic               wk_done = 1'b0;

  // advance the walk by one file byte and queue the word it causes, if any
  task automatic walk_byte(input byte_t b, input logic eof);
    filter_word_t w;
    logic         emit;
    logic         done_now;
    w = '0;
    emit = 1'b0;
    done_now = 1'b0;
    // once the match is complete every byte is dropped until end of file
    if (!wk_done) begin
      case (wk_phase)
        PhLen: begin
          wk_len = {wk_len[WordW-9:0], b};
          if (wk_count == FieldLastByte) begin
            wk_count = '0;
            wk_left = wk_len;
            if (wk_left == '0) begin
              // zero-length chunk: straight back to the tag phase
              wk_phase = PhTag;
              if (wk_hit) begin
                wk_done = 1'b1;
                done_now = 1'b1;
                emit = 1'b1;
                w.payload_last = 1'b1;
              end
            end else begin
              wk_phase = PhPay;
            end
          end else begin
            wk_count = wk_count + 1'b1;
          end
        end
        PhPay: begin
          wk_left = wk_left - 1'b1;
          if (wk_hit) begin
            emit = 1'b1;
            w.payload_valid = 1'b1;
            w.out_byte = b;
            if (wk_left == '0) begin
              w.payload_last = 1'b1;
              wk_done = 1'b1;
              done_now = 1'b1;
            end
          end
          if (wk_left == '0) wk_phase = PhTag;
        end
        default: begin
          // tag phase, and the spare phase code behaves the same way
          wk_tag = {wk_tag[WordW-9:0], b};
          if (wk_count == FieldLastByte) begin
            wk_count = '0;
            wk_hit = (wk_tag == target_model);
            wk_len = '0;
            wk_phase = PhLen;
          end else begin
            wk_count = wk_count + 1'b1;
            wk_phase = PhTag;
          end
        end
      endcase
    end
    if (eof) begin
      // final verdict; a header cut short never counts as a match
      emit = 1'b1;
      if (wk_done) w.status = StFound;
      else if (wk_phase == PhPay && wk_hit) w.status = StTruncated;
      else w.status = StNotFound;
      wk_phase = PhTag;
      wk_count = '0;
      wk_tag = '0;
      wk_len = '0;
      wk_left = '0;
      wk_hit = 1'b0;
      wk_done = 1'b0;
    end else begin
      w.status = done_now ? StFound : StRunning;
    end
    if (emit) want_words = {want_words, w};
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // compare one accepted output word with the oldest prediction
  task automatic check_word();
    filter_word_t want;
    if (want_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte=%02h valid=%b last=%b status=%0d",
                                out_ch.out_byte, out_ch.payload_valid,
                                out_ch.payload_last, out_ch.status));
      return;
    end
    want = want_words.pop_front();
    if (out_ch.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, want.out_byte));
    if (out_ch.payload_valid !== want.payload_valid)
      report_mismatch($sformatf("payload_valid %b, want %b",
                                out_ch.payload_valid, want.payload_valid));
    if (out_ch.payload_last !== want.payload_last)
      report_mismatch($sformatf("payload_last %b, want %b",
                                out_ch.payload_last, want.payload_last));
    if (out_ch.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
  endtask

  // ---------------------------------------------------------------------------
  // driver: sends queued file bytes, with random idle bursts when enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      // the byte on the bus was just taken, so the walk moves on
      if (in_ch.valid && in_ch.ready) walk_byte(in_ch.data_byte, in_ch.end_of_file);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (file_words.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (src_idle && $urandom_range(0, 7) == 0) begin
          // idle burst of random length, starting with this cycle
          src_gap = $urandom_range(0, 15);
          in_ch.valid <= 1'b0;
        end else begin
          next_word = file_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= next_word.data;
          in_ch.end_of_file <= next_word.eof;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes output words, stalling in random bursts when enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // file building
  // ---------------------------------------------------------------------------
  // big-endian, first character in the top byte
  function automatic void put_word(input word_t w);
    for (int k = 0; k < 4; k++) file_buf = {file_buf, byte_t'(w[WordW-1-8*k -: 8])};
  endfunction

  function automatic void put_chunk(input word_t tag, input int unsigned len);
    put_word(tag);
    put_word(word_t'(len));
    repeat (len) file_buf = {file_buf, byte_t'($urandom)};
  endfunction

  // move the built file to the send queue, end_of_file on its last byte
  function automatic void ship_file();
    if (file_buf.size() == 0) file_buf = {file_buf, byte_t'($urandom)};
    foreach (file_buf[i])
      file_words = {file_words, file_word_t'{file_buf[i], i == file_buf.size() - 1}};
    file_buf.delete();
  endfunction

  function automatic word_t pick_tag();
    case ($urandom_range(0, 3))
      0, 1:    pick_tag = target_model;
      2:       pick_tag = target_model ^ (word_t'(1) << $urandom_range(0, 31));
      default: pick_tag = word_t'($urandom);
    endcase
  endfunction

  // one random file; mostly well-formed chunk runs, some cut or noisy
  task automatic build_random_file();
    int unsigned kind;
    int unsigned keep;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // plain noise
      repeat ($urandom_range(1, 12)) file_buf = {file_buf, byte_t'($urandom)};
    end else begin
      repeat ($urandom_range(1, 4))
        put_chunk(pick_tag(), ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                           : $urandom_range(0, 5));
      if (kind == 1) begin
        // file cut at any byte: inside headers, payloads, after the match
        keep = $urandom_range(1, file_buf.size());
        while (file_buf.size() > keep) void'(file_buf.pop_back());
      end else if (kind == 2) begin
        // huge length, file ends long before the payload does
        put_word(pick_tag());
        put_word(32'hFFFF_FF00 | word_t'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4)) file_buf = {file_buf, byte_t'($urandom)};
      end else if (kind == 3) begin
        // header cut short, its tag being the target
        put_word(target_model);
        put_word(word_t'($urandom_range(0, 3)));
        keep = file_buf.size() - $urandom_range(1, 7);
        while (file_buf.size() > keep) void'(file_buf.pop_back());
      end
    end
    live_words += file_buf.size();
    // trailing junk, dropped by the filter once a match is complete
    if (kind >= 4) repeat ($urandom_range(0, 4)) file_buf = {file_buf, byte_t'($urandom)};
    ship_file();
  endtask

  // hold off until every byte is taken and every predicted word has come,
  // then idle on for bytes that make no word
  task automatic settle();
    while (file_words.size() != 0 || in_ch.valid || want_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_target(input word_t tag);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= tag;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    target_model = tag;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    word_t round_tag[5];
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_file = 1'b0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed files, target still at its reset value of zero
    // a lone byte that is the whole file
    file_buf = {file_buf, 8'h00};
    ship_file();
    // header cut short although the partial tag matches
    repeat (3) file_buf = {file_buf, 8'h00};
    ship_file();
    // match with two payload bytes, the last one also ending the file
    put_word(32'h0000_0000);
    put_word(32'h0000_0002);
    file_buf = {file_buf, 8'hFF};
    file_buf = {file_buf, 8'h00};
    ship_file();
    settle();

    // all-ones target, huge length, file ends inside the matching payload
    set_target(32'hFFFF_FFFF);
    put_word(32'hFFFF_FFFF);
    put_word(32'hFFFF_FFFF);
    file_buf = {file_buf, 8'hA5};
    ship_file();
    // zero-length match completed on the byte that ends the file
    put_word(32'hFFFF_FFFF);
    put_word(32'h0000_0000);
    ship_file();

    // random rounds, each setting its target and idling mix
    round_tag = '{32'h0000_0000, 32'hFFFF_FFFF, word_t'($urandom), word_t'($urandom),
                  32'h4441_5441};
    for (int r = 0; r < 5; r++) begin
      settle();
      set_target(round_tag[r]);
      src_idle  = (r == 0 || r == 1 || r == 3);
      sink_idle = (r == 0 || r == 2 || r == 3);
      while (live_words < LiveWordsPerRound * (r + 1)) begin
        build_random_file();
        // now and then let the sender wait for the filter to drain
        if ($urandom_range(0, 14) == 0) settle();
      end
    end

    // everything sent, then wait for the last words with a bound
    while (file_words.size() != 0 || in_ch.valid) @(negedge clk);
    for (int n = 0; n < DrainLimit && want_words.size() != 0; n++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (want_words.size() != 0)
      report_mismatch($sformatf("%0d predicted words never came", want_words.size()));

    if (mismatches == 0) begin
      $display("** chunk_stream_id_filter: PASSED **");
    end else begin
      $display("** chunk_stream_id_filter: FAILED **");
    end
    $finish;
  end

  // hard stop in case the filter hangs
  initial begin
    #(TimeLimitNs);
    $display("** chunk_stream_id_filter: FAILED **");
    $finish;
  end

endmodule
